// File: rtl/wis_pkg.sv
// Shared constants and controller/datapath bundles for weighted interval scheduling.
`default_nettype none

package wis_pkg;

  localparam int unsigned MAX_ITEMS_DEF  = 64;
  localparam int unsigned TIME_BITS_DEF  = 16;
  localparam int unsigned VALUE_BITS_DEF = 16;

  localparam int unsigned IO_TIME_BITS   = 16;
  localparam int unsigned IO_VALUE_BITS  = 16;
  localparam int unsigned TOTAL_OUT_BITS = 22;

  localparam logic [TOTAL_OUT_BITS-1:0] TOTAL_MAX = 22'h3FFFFF;

  typedef struct packed {
    logic accept;
    logic scan;
    logic lookup;
    logic update;
    logic trace_init;
    logic trace_rd;
    logic trace_eval;
    logic finish;
  } wis_cmd_t;

  typedef struct packed {
    logic full;
    logic k_zero;
    logic k_one;
    logic overlap;
  } wis_stat_t;

endpackage

`default_nettype wire

// File: rtl/weighted_interval_scheduling.sv
// Top level of the weighted interval scheduling block.
//
// Requests (start, finish, value, last flag) are taken at a rising edge with
// start high and busy low, sorted by non-decreasing finish time. Each request
// scans back over the stored intervals, one per cycle, for its latest
// non-overlapping predecessor, then updates the best total before the next
// request can be accepted, so the wait grows with the number of intervals
// scanned. A dropped request skips the scan and the update.
// A request marked last starts the traceback, which emits the chosen
// intervals in decreasing index order. Each result is shown for exactly
// one cycle with result_strobe_o high; the receiver cannot stall, so no
// result waits. An empty selection gives one result with has_interval_o
// low. Requests beyond MAX_ITEMS are dropped and flagged on every result
// of the set.
// Reset clears the item count and flags; the stores need no clearing pass
// and the block accepts a request in the first cycle after reset.
`default_nettype none

module weighted_interval_scheduling #(
  parameter int unsigned MAX_ITEMS  = wis_pkg::MAX_ITEMS_DEF,
  parameter int unsigned TIME_BITS  = wis_pkg::TIME_BITS_DEF,
  parameter int unsigned VALUE_BITS = wis_pkg::VALUE_BITS_DEF
) (
  input  wire logic                              clk_i,
  input  wire logic                              rst_ni,
  input  wire logic                              start,
  output logic                                   busy,
  input  wire logic [wis_pkg::IO_TIME_BITS-1:0]  in_start_i,
  input  wire logic [wis_pkg::IO_TIME_BITS-1:0]  in_finish_i,
  input  wire logic [wis_pkg::IO_VALUE_BITS-1:0] in_value_i,
  input  wire logic                              last_item_i,
  output logic                                   result_strobe_o,
  output logic [wis_pkg::IO_TIME_BITS-1:0]       out_start_o,
  output logic [wis_pkg::IO_TIME_BITS-1:0]       out_finish_o,
  output logic [wis_pkg::IO_VALUE_BITS-1:0]      out_value_o,
  output logic [wis_pkg::TOTAL_OUT_BITS-1:0]     total_value_o,
  output logic                                   has_interval_o,
  output logic                                   dropped_items_o,
  output logic                                   last_result_o
);

  wis_pkg::wis_cmd_t  cmd;
  wis_pkg::wis_stat_t stat;

  wis_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .start       (start),
    .last_item_i (last_item_i),
    .stat_i      (stat),
    .busy        (busy),
    .cmd_o       (cmd)
  );

  wis_dp #(
    .MAX_ITEMS  (MAX_ITEMS),
    .TIME_BITS  (TIME_BITS),
    .VALUE_BITS (VALUE_BITS)
  ) u_dp (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cmd_i           (cmd),
    .stat_o          (stat),
    .in_start_i      (in_start_i),
    .in_finish_i     (in_finish_i),
    .in_value_i      (in_value_i),
    .result_strobe_o (result_strobe_o),
    .out_start_o     (out_start_o),
    .out_finish_o    (out_finish_o),
    .out_value_o     (out_value_o),
    .total_value_o   (total_value_o),
    .has_interval_o  (has_interval_o),
    .dropped_items_o (dropped_items_o),
    .last_result_o   (last_result_o)
  );

endmodule

`default_nettype wire

// File: rtl/wis_ctrl.sv
// Sequencing state machine for weighted interval scheduling.
`default_nettype none

module wis_ctrl (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              start,
  input  wire logic              last_item_i,
  input  wis_pkg::wis_stat_t     stat_i,
  output logic                   busy,
  output wis_pkg::wis_cmd_t      cmd_o
);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SCAN,
    ST_LOOKUP,
    ST_UPDATE,
    ST_TRACE_INIT,
    ST_TRACE_RD,
    ST_TRACE_EVAL,
    ST_FINISH
  } state_e;

  state_e state_q;
  logic   last_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      last_q  <= 1'b0;
    end else begin
      case (state_q)
        ST_IDLE: begin
          if (start) begin
            last_q <= last_item_i;
            if (stat_i.full) begin
              state_q <= last_item_i ? ST_TRACE_INIT : ST_IDLE;
            end else begin
              state_q <= ST_SCAN;
            end
          end
        end
        ST_SCAN: begin
          if (stat_i.k_zero || !stat_i.overlap || stat_i.k_one) begin
            state_q <= ST_LOOKUP;
          end
        end
        ST_LOOKUP:     state_q <= ST_UPDATE;
        ST_UPDATE:     state_q <= last_q ? ST_TRACE_INIT : ST_IDLE;
        ST_TRACE_INIT: state_q <= ST_TRACE_RD;
        ST_TRACE_RD:   state_q <= stat_i.k_zero ? ST_FINISH : ST_TRACE_EVAL;
        ST_TRACE_EVAL: state_q <= ST_TRACE_RD;
        ST_FINISH:     state_q <= ST_IDLE;
        default:       state_q <= ST_IDLE;
      endcase
    end
  end

  assign busy = (state_q != ST_IDLE);

  always_comb begin
    cmd_o            = '0;
    cmd_o.accept     = (state_q == ST_IDLE) && start;
    cmd_o.scan       = (state_q == ST_SCAN);
    cmd_o.lookup     = (state_q == ST_LOOKUP);
    cmd_o.update     = (state_q == ST_UPDATE);
    cmd_o.trace_init = (state_q == ST_TRACE_INIT);
    cmd_o.trace_rd   = (state_q == ST_TRACE_RD);
    cmd_o.trace_eval = (state_q == ST_TRACE_EVAL);
    cmd_o.finish     = (state_q == ST_FINISH);
  end

  a_finish_to_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_FINISH) |=> !busy)
    else $error("finish did not return to idle");

  a_trace_only_after_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_UPDATE) && !last_q |=> (state_q == ST_IDLE))
    else $error("traceback started without last request");

  a_scan_exit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_SCAN) && stat_i.k_zero |=> (state_q == ST_LOOKUP))
    else $error("scan continued past index zero");

endmodule

`default_nettype wire

// File: rtl/wis_dp.sv
// Datapath: interval stores, predecessor scan, best totals and traceback.
`default_nettype none

module wis_dp #(
  parameter int unsigned MAX_ITEMS  = wis_pkg::MAX_ITEMS_DEF,
  parameter int unsigned TIME_BITS  = wis_pkg::TIME_BITS_DEF,
  parameter int unsigned VALUE_BITS = wis_pkg::VALUE_BITS_DEF
) (
  input  wire logic                                clk_i,
  input  wire logic                                rst_ni,
  input  wis_pkg::wis_cmd_t                        cmd_i,
  output wis_pkg::wis_stat_t                       stat_o,
  input  wire logic [wis_pkg::IO_TIME_BITS-1:0]    in_start_i,
  input  wire logic [wis_pkg::IO_TIME_BITS-1:0]    in_finish_i,
  input  wire logic [wis_pkg::IO_VALUE_BITS-1:0]   in_value_i,
  output logic                                     result_strobe_o,
  output logic [wis_pkg::IO_TIME_BITS-1:0]         out_start_o,
  output logic [wis_pkg::IO_TIME_BITS-1:0]         out_finish_o,
  output logic [wis_pkg::IO_VALUE_BITS-1:0]        out_value_o,
  output logic [wis_pkg::TOTAL_OUT_BITS-1:0]       total_value_o,
  output logic                                     has_interval_o,
  output logic                                     dropped_items_o,
  output logic                                     last_result_o
);

  localparam int unsigned CNT_BITS   = $clog2(MAX_ITEMS + 1);
  localparam int unsigned ADDR_BITS  = (MAX_ITEMS > 1) ? $clog2(MAX_ITEMS) : 1;
  localparam int unsigned TOTAL_BITS = VALUE_BITS + CNT_BITS;
  localparam int unsigned SAT_BITS   = (TOTAL_BITS > wis_pkg::TOTAL_OUT_BITS) ?
                                       TOTAL_BITS : wis_pkg::TOTAL_OUT_BITS;

  logic [TIME_BITS-1:0]  start_mem  [MAX_ITEMS];
  logic [TIME_BITS-1:0]  finish_mem [MAX_ITEMS];
  logic [VALUE_BITS-1:0] value_mem  [MAX_ITEMS];
  logic [TOTAL_BITS-1:0] best_mem   [MAX_ITEMS];
  logic [CNT_BITS-1:0]   prev_mem   [MAX_ITEMS];
  logic                  take_mem   [MAX_ITEMS];

  logic [CNT_BITS-1:0]   cnt_q;
  logic                  ovf_q;
  logic [TOTAL_BITS-1:0] best_last_q;
  logic                  pend_valid_q;
  logic                  strobe_q;
  logic [CNT_BITS-1:0]   k_q;

  logic [TIME_BITS-1:0]  cur_start_q, cur_finish_q;
  logic [VALUE_BITS-1:0] cur_value_q;
  logic [TIME_BITS-1:0]  rd_start_q, rd_finish_q;
  logic [VALUE_BITS-1:0] rd_value_q;
  logic [TOTAL_BITS-1:0] rd_best_q;
  logic [CNT_BITS-1:0]   rd_prev_q;
  logic                  rd_take_q;
  logic [TIME_BITS-1:0]  pend_start_q, pend_finish_q;
  logic [VALUE_BITS-1:0] pend_value_q;

  logic [wis_pkg::IO_TIME_BITS-1:0]   out_start_q, out_finish_q;
  logic [wis_pkg::IO_VALUE_BITS-1:0]  out_value_q;
  logic [wis_pkg::TOTAL_OUT_BITS-1:0] total_q;
  logic                               has_q, drop_q, last_q;

  logic [TIME_BITS-1:0]  in_start, in_finish;
  logic [VALUE_BITS-1:0] in_value;
  logic [ADDR_BITS-1:0]  wr_addr, item_raddr, sol_raddr;
  logic [CNT_BITS-1:0]   k_dec, k_dec2, cnt_dec;
  logic                  full, k_zero, k_one, overlap;
  logic [TOTAL_BITS-1:0] best_prev, with_item, best_new;
  logic                  take_new, emit_pend;
  logic [SAT_BITS-1:0]   tot_w;
  logic [wis_pkg::TOTAL_OUT_BITS-1:0] tot_sat;

  assign in_start  = TIME_BITS'(in_start_i);
  assign in_finish = TIME_BITS'(in_finish_i);
  assign in_value  = VALUE_BITS'(in_value_i);

  assign k_dec   = k_q - CNT_BITS'(1);
  assign k_dec2  = k_q - CNT_BITS'(2);
  assign cnt_dec = cnt_q - CNT_BITS'(1);
  assign full    = (cnt_q == CNT_BITS'(MAX_ITEMS));
  assign k_zero  = (k_q == '0);
  assign k_one   = (k_q == CNT_BITS'(1));

  assign overlap = (rd_start_q <= cur_start_q && cur_start_q <= rd_finish_q) ||
                   (rd_start_q <= cur_finish_q && cur_finish_q <= rd_finish_q) ||
                   (cur_start_q <= rd_start_q && rd_start_q <= cur_finish_q) ||
                   (cur_start_q <= rd_finish_q && rd_finish_q <= cur_finish_q);

  assign stat_o = '{full: full, k_zero: k_zero, k_one: k_one, overlap: overlap};

  assign wr_addr   = cnt_q[ADDR_BITS-1:0];
  assign sol_raddr = k_dec[ADDR_BITS-1:0];

  always_comb begin
    if (cmd_i.accept) begin
      item_raddr = cnt_dec[ADDR_BITS-1:0];
    end else if (cmd_i.scan && overlap && !k_zero) begin
      item_raddr = k_dec2[ADDR_BITS-1:0];
    end else begin
      item_raddr = k_dec[ADDR_BITS-1:0];
    end
  end

  assign best_prev = k_zero ? '0 : rd_best_q;
  assign with_item = TOTAL_BITS'(cur_value_q) + best_prev;
  assign take_new  = (with_item > best_last_q);
  assign best_new  = take_new ? with_item : best_last_q;

  assign tot_w   = SAT_BITS'(best_last_q);
  assign tot_sat = (tot_w > SAT_BITS'(wis_pkg::TOTAL_MAX)) ? wis_pkg::TOTAL_MAX :
                   wis_pkg::TOTAL_OUT_BITS'(tot_w);

  assign emit_pend = cmd_i.trace_eval && rd_take_q && pend_valid_q;

  always_ff @(posedge clk_i) begin
    if (cmd_i.accept && !full) begin
      start_mem[wr_addr]  <= in_start;
      finish_mem[wr_addr] <= in_finish;
      value_mem[wr_addr]  <= in_value;
    end
    if (cmd_i.update) begin
      best_mem[wr_addr] <= best_new;
      prev_mem[wr_addr] <= k_q;
      take_mem[wr_addr] <= take_new;
    end
    rd_start_q  <= start_mem[item_raddr];
    rd_finish_q <= finish_mem[item_raddr];
    rd_value_q  <= value_mem[item_raddr];
    rd_best_q   <= best_mem[sol_raddr];
    rd_prev_q   <= prev_mem[sol_raddr];
    rd_take_q   <= take_mem[sol_raddr];
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.accept) begin
      cur_start_q  <= in_start;
      cur_finish_q <= in_finish;
      cur_value_q  <= in_value;
      k_q          <= cnt_q;
    end else if (cmd_i.scan) begin
      if (overlap && !k_zero) begin
        k_q <= k_dec;
      end
    end else if (cmd_i.trace_init) begin
      k_q <= cnt_q;
    end else if (cmd_i.trace_eval) begin
      k_q <= rd_take_q ? rd_prev_q : k_dec;
    end
    if (cmd_i.trace_eval && rd_take_q) begin
      pend_start_q  <= rd_start_q;
      pend_finish_q <= rd_finish_q;
      pend_value_q  <= rd_value_q;
    end
    if (emit_pend || (cmd_i.finish && pend_valid_q)) begin
      out_start_q  <= wis_pkg::IO_TIME_BITS'(pend_start_q);
      out_finish_q <= wis_pkg::IO_TIME_BITS'(pend_finish_q);
      out_value_q  <= wis_pkg::IO_VALUE_BITS'(pend_value_q);
      total_q      <= tot_sat;
      has_q        <= 1'b1;
      drop_q       <= ovf_q;
      last_q       <= cmd_i.finish;
    end else if (cmd_i.finish) begin
      out_start_q  <= '0;
      out_finish_q <= '0;
      out_value_q  <= '0;
      total_q      <= '0;
      has_q        <= 1'b0;
      drop_q       <= ovf_q;
      last_q       <= 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q        <= '0;
      ovf_q        <= 1'b0;
      best_last_q  <= '0;
      pend_valid_q <= 1'b0;
      strobe_q     <= 1'b0;
    end else begin
      strobe_q <= emit_pend || cmd_i.finish;
      if (cmd_i.accept && full) begin
        ovf_q <= 1'b1;
      end
      if (cmd_i.update) begin
        cnt_q       <= cnt_q + CNT_BITS'(1);
        best_last_q <= best_new;
      end
      if (cmd_i.trace_init) begin
        pend_valid_q <= 1'b0;
      end else if (cmd_i.trace_eval && rd_take_q) begin
        pend_valid_q <= 1'b1;
      end
      if (cmd_i.finish) begin
        cnt_q       <= '0;
        ovf_q       <= 1'b0;
        best_last_q <= '0;
      end
    end
  end

  assign result_strobe_o = strobe_q;
  assign out_start_o     = out_start_q;
  assign out_finish_o    = out_finish_q;
  assign out_value_o     = out_value_q;
  assign total_value_o   = total_q;
  assign has_interval_o  = has_q;
  assign dropped_items_o = drop_q;
  assign last_result_o   = last_q;

  a_cnt_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= CNT_BITS'(MAX_ITEMS))
    else $error("item count beyond capacity");

  a_strobe_src: assert property (@(posedge clk_i) disable iff (!rst_ni)
    strobe_q |-> $past(cmd_i.trace_eval || cmd_i.finish))
    else $error("result strobe without traceback step");

  a_empty_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    strobe_q && !has_q |-> last_q && (total_q == '0))
    else $error("empty result not final or carries a total");

  a_finish_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.finish |=> strobe_q && last_q)
    else $error("set ended without a final result");

endmodule

`default_nettype wire
